// ===== rtl/round_robin_slice_scheduler_assert.svh =====
// Assertion macros shared by the scheduler RTL modules.
// Each using module must have clk_i and rst_ni in scope.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RRSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rrss_pkg.sv =====
// Package for the round-robin slice scheduler.
// Holds the transaction payload types, the control/status structs and the widths.
// No dependencies.
package rrss_pkg;

  // Fixed field widths.
  localparam int unsigned BURST_W           = 16;
  localparam int unsigned TIME_W            = 21;
  localparam int unsigned OUT_TIME_W        = 20;
  localparam int unsigned PID_W             = 5;
  localparam int unsigned MAX_PROCESSES_DEF = 16;
  localparam logic [BURST_W-1:0] QUANTUM_RESET = BURST_W'(1);

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_SLICE = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [BURST_W-1:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [PID_W-1:0]      process_id;
    logic [OUT_TIME_W-1:0] start_time;
    logic [OUT_TIME_W-1:0] end_time;
    logic [BURST_W-1:0]    slice_length;
    logic                  finished;
    logic                  all_done;
    logic                  load_dropped;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic step;    // read the table entry at the scan index
    logic check;   // examine the entry read in the previous cycle
    logic emit;    // move the staged result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic table_full;
    logic no_live;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/round_robin_slice_scheduler.sv =====
// Round-robin time-slice scheduler: load bursts, hand out slices in rotating
// order, and report each slice. A load or clear transaction produces no result
// unless the load is dropped; a dropped load or a slice request with nothing left
// goes straight to the staged result. A slice request probes between one entry and
// the process count of table entries: the table has one read port with a
// registered read, so each probe is a read step followed by a check step. The output
// register lets a new transaction be taken while the previous result waits.
// Depends on rrss_pkg, rrss_ctrl and rrss_datapath.
module round_robin_slice_scheduler #(
  parameter int unsigned MAX_PROCESSES = rrss_pkg::MAX_PROCESSES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rrss_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rrss_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rrss_pkg::BURST_W-1:0] cfg_data_i
);
  import rrss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The quantum register is always writable.
  assign cfg_ready_o = 1'b1;

  rrss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (in_item_i.mode),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrss_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/rrss_ctrl.sv =====
// Controller state machine of the round-robin slice scheduler.
// Depends on rrss_pkg and the assertion macro header.
`include "round_robin_slice_scheduler_assert.svh"

module rrss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rrss_pkg::mode_e     mode_i,
  input  rrss_pkg::dp_status_t status_i,
  output rrss_pkg::dp_cmd_t   cmd_o
);
  import rrss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   accept;

  // Items are taken only between transactions.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  assign cmd_o.accept = accept;
  assign cmd_o.step   = (state_q == S_READ);
  assign cmd_o.check  = (state_q == S_CHECK);
  assign cmd_o.emit   = (state_q == S_EMIT) && status_i.out_free;

  // State register and transitions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (mode_i)
              MODE_LOAD:  state_q <= status_i.table_full ? S_EMIT : S_IDLE;
              MODE_SLICE: state_q <= status_i.no_live ? S_EMIT : S_READ;
              MODE_CLEAR: state_q <= S_IDLE;
              MODE_NONE:  state_q <= S_IDLE;
              default:    state_q <= S_IDLE;
            endcase
          end
        end
        S_READ:  state_q <= S_CHECK;
        S_CHECK: state_q <= status_i.hit ? S_EMIT : S_READ;
        S_EMIT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A missed probe must go on scanning, and a blocked result must wait.
  `RRSS_ASSERT_NEXT(a_miss_rescans, (state_q == S_CHECK) && !status_i.hit, state_q == S_READ, "scan stopped on an empty entry")
  `RRSS_ASSERT_NEXT(a_emit_holds, (state_q == S_EMIT) && !status_i.out_free, state_q == S_EMIT, "staged result left before output was free")
  `RRSS_ASSERT_NOW(a_no_accept_busy, state_q != S_IDLE, !cmd_o.accept, "transaction accepted while busy")

endmodule

// ===== rtl/rrss_datapath.sv =====
// Datapath of the round-robin slice scheduler: process table, time, quantum, output.
// Depends on rrss_pkg and the assertion macro header.
`include "round_robin_slice_scheduler_assert.svh"

module rrss_datapath #(
  parameter int unsigned MAX_PROCESSES = rrss_pkg::MAX_PROCESSES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrss_pkg::in_item_t         in_item_i,
  input  rrss_pkg::dp_cmd_t          cmd_i,
  output rrss_pkg::dp_status_t       status_o,
  input  logic                       cfg_valid_i,
  input  logic [rrss_pkg::BURST_W-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rrss_pkg::out_item_t        out_item_o
);
  import rrss_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);

  // Remaining time per process; entries at or above the count are never read.
  logic [BURST_W-1:0] rem_mem [MAX_PROCESSES];
  logic [BURST_W-1:0] rd_q;

  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   live_q;
  logic [IDX_W-1:0]   next_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TIME_W-1:0]  time_q;
  logic [BURST_W-1:0] quantum_q;
  out_item_t          res_q;
  out_item_t          res_d;
  out_item_t          out_q;
  logic               out_valid_q;

  logic               table_full;
  logic               do_load;
  logic               do_slice;
  logic               do_clear;
  logic [IDX_W-1:0]   start_idx;
  logic [CNT_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   idx_wrap;
  logic [BURST_W-1:0] q_eff;
  logic               short_run;
  logic [BURST_W-1:0] slice_len;
  logic [BURST_W-1:0] new_rem;
  logic [TIME_W-1:0]  end_time;
  logic               finished;
  logic [CNT_W-1:0]   live_after;
  logic               hit;

  assign table_full = (count_q >= CNT_W'(MAX_PROCESSES));
  assign do_load    = cmd_i.accept && (in_item_i.mode == MODE_LOAD);
  assign do_slice   = cmd_i.accept && (in_item_i.mode == MODE_SLICE);
  assign do_clear   = cmd_i.accept && (in_item_i.mode == MODE_CLEAR);

  // Scan start: the saved index, or the first entry if the table shrank below it.
  assign start_idx = (CNT_W'(next_q) >= count_q) ? '0 : next_q;
  assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
  assign idx_wrap  = (idx_inc >= count_q) ? '0 : idx_inc[IDX_W-1:0];

  // Slice arithmetic on the entry read in the previous cycle.
  assign hit        = (rd_q != '0);
  assign q_eff      = (quantum_q == '0) ? BURST_W'(1) : quantum_q;
  assign short_run  = (rd_q < q_eff);
  assign slice_len  = short_run ? rd_q : q_eff;
  assign new_rem    = short_run ? '0 : (rd_q - q_eff);
  assign end_time   = time_q + TIME_W'(slice_len);
  assign finished   = (new_rem == '0);
  assign live_after = live_q - CNT_W'(finished);

  assign status_o.table_full = table_full;
  assign status_o.no_live    = (live_q == '0);
  assign status_o.hit        = hit;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (do_load && !table_full) begin
      rem_mem[count_q[IDX_W-1:0]] <= in_item_i.burst_time;
    end else if (cmd_i.check && hit) begin
      rem_mem[idx_q] <= new_rem;
    end
    if (cmd_i.step) begin
      rd_q <= rem_mem[idx_q];
    end
  end

  // Table bookkeeping, clock and quantum register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      live_q    <= '0;
      next_q    <= '0;
      time_q    <= '0;
      quantum_q <= QUANTUM_RESET;
    end else begin
      if (cfg_valid_i) begin
        quantum_q <= cfg_data_i;
      end
      if (do_load && !table_full) begin
        count_q <= count_q + CNT_W'(1);
        if (in_item_i.burst_time != '0) begin
          live_q <= live_q + CNT_W'(1);
        end
      end else if (do_clear) begin
        count_q <= '0;
        live_q  <= '0;
        next_q  <= '0;
        time_q  <= '0;
      end else if (cmd_i.check && hit) begin
        live_q <= live_after;
        next_q <= idx_wrap;
        time_q <= end_time;
      end
    end
  end

  // Next staged result: a dropped load, a report that no process is left, or a slice report.
  always_comb begin
    res_d = res_q;
    if (do_load) begin
      res_d              = '0;
      res_d.load_dropped = 1'b1;
    end else if (do_slice) begin
      res_d            = '0;
      res_d.start_time = time_q[OUT_TIME_W-1:0];
      res_d.end_time   = time_q[OUT_TIME_W-1:0];
      res_d.all_done   = 1'b1;
    end else if (cmd_i.check && hit) begin
      res_d.process_id   = PID_W'(idx_inc);
      res_d.start_time   = time_q[OUT_TIME_W-1:0];
      res_d.end_time     = end_time[OUT_TIME_W-1:0];
      res_d.slice_length = slice_len;
      res_d.finished     = finished;
      res_d.all_done     = (live_after == '0);
      res_d.load_dropped = 1'b0;
    end
  end

  // Scan index and staged result.
  always_ff @(posedge clk_i) begin
    if (do_slice) begin
      idx_q <= start_idx;
    end else if (cmd_i.check && !hit) begin
      idx_q <= idx_wrap;
    end
    res_q <= res_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  `RRSS_ASSERT_NOW(a_live_le_count, 1'b1, live_q <= count_q, "more live processes than loaded")
  `RRSS_ASSERT_NOW(a_scan_in_table, cmd_i.step, CNT_W'(idx_q) < count_q, "scan index outside the table")
  `RRSS_ASSERT_NEXT(a_emit_valid, cmd_i.emit, out_valid_q, "emitted result not presented")

endmodule
